/* rtl/epm_pkg.sv */
package epm_pkg;

    localparam int CordicSteps = 16;
    localparam int AtanEntries = 24;
    localparam int NSteps = (CordicSteps > AtanEntries) ? AtanEntries : CordicSteps;

    localparam logic signed [33:0] CordicX0 = 34'sd652032874;
    localparam logic signed [33:0] OneQ30 = 34'sd1073741824;

    typedef logic signed [33:0] t_cval;

    typedef struct packed {
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_pose;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [31:0] tx;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [31:0] ty;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
        logic signed [31:0] tz;
    } t_matrix;

    // Front-end classification: nearest quadrant and residual per axis.
    typedef struct packed {
        logic [1:0] q_x;
        logic [1:0] q_y;
        logic [1:0] q_z;
        logic signed [15:0] r_x;
        logic signed [15:0] r_y;
        logic signed [15:0] r_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_job;

    function automatic logic signed [32:0] atan_entry(input int idx);
        logic signed [32:0] v;
        unique case (idx)
            0: v = 33'sd536870912;
            1: v = 33'sd316933406;
            2: v = 33'sd167458907;
            3: v = 33'sd85004756;
            4: v = 33'sd42667331;
            5: v = 33'sd21354465;
            6: v = 33'sd10679838;
            7: v = 33'sd5340245;
            8: v = 33'sd2670163;
            9: v = 33'sd1335087;
            10: v = 33'sd667544;
            11: v = 33'sd333772;
            12: v = 33'sd166886;
            13: v = 33'sd83443;
            14: v = 33'sd41722;
            15: v = 33'sd20861;
            16: v = 33'sd10430;
            17: v = 33'sd5215;
            18: v = 33'sd2608;
            19: v = 33'sd1304;
            20: v = 33'sd652;
            21: v = 33'sd326;
            22: v = 33'sd163;
            default: v = 33'sd81;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] to_q14(input logic signed [63:0] v60);
        logic signed [63:0] v;
        v = (v60 + (64'sd1 <<< 45)) >>> 46;
        if (v < -64'sd16384) begin
            v = -64'sd16384;
        end else if (v > 64'sd16384) begin
            v = 64'sd16384;
        end
        return v[15:0];
    endfunction

endpackage

/* rtl/epm_stream_if.sv */
interface epm_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/euler_pose_to_model_matrix_unit.sv */
// An accepted item passes the front queue register, the CORDIC load stage, one stage per
// step, quadrant and clamp, two product stages and the output register before its result
// is offered.
// Throughput: one item per cycle while the result side does not stall, set by the fully
// pipelined CORDIC and product stages; the front queue absorbs a stall of the result side.
// Reset (synchronous, active low) empties the queue and clears all valid bits.
module euler_pose_to_model_matrix_unit (
    input logic i_clk,
    input logic i_rst_n,
    epm_stream_if.sink   i_pose,
    epm_stream_if.source o_mat
);
    import epm_pkg::*;

    // The front end splits each angle into a quadrant and a residual and
    // queues the item; the back end runs the CORDIC and the products.
    logic  job_valid;
    logic  job_ready;
    t_job  job;

    epm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pose.valid),
        .o_ready (i_pose.ready),
        .i_pose  (i_pose.data),
        .o_valid (job_valid),
        .i_ready (job_ready),
        .o_job   (job)
    );

    epm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (job_valid),
        .o_ready (job_ready),
        .i_job   (job),
        .o_valid (o_mat.valid),
        .i_ready (o_mat.ready),
        .o_mat   (o_mat.data)
    );
endmodule

/* rtl/epm_front.sv */
module epm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  epm_pkg::t_pose i_pose,
    output logic          o_valid,
    input  logic          i_ready,
    output epm_pkg::t_job o_job
);
    import epm_pkg::*;

    // Two-entry skid queue between the classifier and the back end.
    t_job r_q0, r_q1, n_job;
    logic r_v0, r_v1;

    function automatic logic [1:0] quad(input logic [15:0] a);
        logic [15:0] t;
        t = a + 16'h2000;
        return t[15:14];
    endfunction

    function automatic logic [15:0] resid(input logic [15:0] a, input logic [1:0] q);
        return a - {q, 14'd0};
    endfunction

    always_comb begin
        n_job.q_x = quad(i_pose.angle_x);
        n_job.q_y = quad(i_pose.angle_y);
        n_job.q_z = quad(i_pose.angle_z);
        n_job.r_x = resid(i_pose.angle_x, n_job.q_x);
        n_job.r_y = resid(i_pose.angle_y, n_job.q_y);
        n_job.r_z = resid(i_pose.angle_z, n_job.q_z);
        n_job.pos_x = i_pose.pos_x;
        n_job.pos_y = i_pose.pos_y;
        n_job.pos_z = i_pose.pos_z;
    end

    assign o_ready = !r_v1;
    assign o_valid = r_v0;
    assign o_job = r_q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            logic push, pop;
            push = i_valid && o_ready;
            pop = r_v0 && i_ready;
            if (pop) begin
                if (r_v1) begin
                    r_q0 <= r_q1;
                    r_v1 <= 1'b0;
                    if (push) begin
                        r_q1 <= n_job;
                        r_v1 <= 1'b1;
                    end
                end else if (push) begin
                    r_q0 <= n_job;
                end else begin
                    r_v0 <= 1'b0;
                end
            end else if (push) begin
                if (r_v0) begin
                    r_q1 <= n_job;
                    r_v1 <= 1'b1;
                end else begin
                    r_q0 <= n_job;
                    r_v0 <= 1'b1;
                end
            end
        end
    end
endmodule

/* rtl/epm_back.sv */
module epm_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  epm_pkg::t_job    i_job,
    output logic             o_valid,
    input  logic             i_ready,
    output epm_pkg::t_matrix o_mat
);
    import epm_pkg::*;

    // Stages: a load stage, NSteps CORDIC steps, quadrant/clamp, two product stages,
    // then the sums into the output register. The whole pipe advances when the
    // output is free.
    localparam int Depth = NSteps + 5;

    logic adv;
    logic [Depth-1:0] r_vld;

    t_cval r_x [0:2][0:NSteps];
    t_cval r_y [0:2][0:NSteps];
    logic signed [32:0] r_z [0:2][0:NSteps];
    logic [1:0] r_q [0:2][0:NSteps];
    logic signed [31:0] r_p [0:2][0:Depth-2];

    assign adv = !r_vld[Depth-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[Depth-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[Depth-2:0], i_valid};
        end
    end

    logic signed [15:0] in_r [0:2];
    logic [1:0] in_q [0:2];
    assign in_r[0] = i_job.r_x;
    assign in_r[1] = i_job.r_y;
    assign in_r[2] = i_job.r_z;
    assign in_q[0] = i_job.q_x;
    assign in_q[1] = i_job.q_y;
    assign in_q[2] = i_job.q_z;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int a = 0; a < 3; a++) begin
                r_x[a][0] <= CordicX0;
                r_y[a][0] <= '0;
                r_z[a][0] <= {in_r[a][15], in_r[a], 16'd0};
                r_q[a][0] <= in_q[a];
            end
            for (int s = 0; s < NSteps; s++) begin
                for (int a = 0; a < 3; a++) begin
                    if (!r_z[a][s][32]) begin
                        r_x[a][s+1] <= r_x[a][s] - (r_y[a][s] >>> s);
                        r_y[a][s+1] <= r_y[a][s] + (r_x[a][s] >>> s);
                        r_z[a][s+1] <= r_z[a][s] - atan_entry(s);
                    end else begin
                        r_x[a][s+1] <= r_x[a][s] + (r_y[a][s] >>> s);
                        r_y[a][s+1] <= r_y[a][s] - (r_x[a][s] >>> s);
                        r_z[a][s+1] <= r_z[a][s] + atan_entry(s);
                    end
                    r_q[a][s+1] <= r_q[a][s];
                end
            end
            r_p[0][0] <= i_job.pos_x;
            r_p[1][0] <= i_job.pos_y;
            r_p[2][0] <= i_job.pos_z;
            for (int k = 0; k < Depth - 2; k++) begin
                for (int a = 0; a < 3; a++) begin
                    r_p[a][k+1] <= r_p[a][k];
                end
            end
        end
    end

    function automatic t_cval clampc(input t_cval v);
        if (v > OneQ30) return OneQ30;
        if (v < -OneQ30) return -OneQ30;
        return v;
    endfunction

    t_cval r_s [0:2];
    t_cval r_c [0:2];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int a = 0; a < 3; a++) begin
                unique case (r_q[a][NSteps])
                    2'd0: begin r_c[a] <= clampc(r_x[a][NSteps]);
                                r_s[a] <= clampc(r_y[a][NSteps]); end
                    2'd1: begin r_c[a] <= clampc(-r_y[a][NSteps]);
                                r_s[a] <= clampc(r_x[a][NSteps]); end
                    2'd2: begin r_c[a] <= clampc(-r_x[a][NSteps]);
                                r_s[a] <= clampc(-r_y[a][NSteps]); end
                    default: begin r_c[a] <= clampc(r_y[a][NSteps]);
                                r_s[a] <= clampc(-r_x[a][NSteps]); end
                endcase
            end
        end
    end

    // Stage A: sy*sx and sy*cx rounded to Q30, carry the rest along.
    logic signed [63:0] sysx_w, sycx_w;
    assign sysx_w = 64'(r_s[1]) * 64'(r_s[0]) + (64'sd1 <<< 29);
    assign sycx_w = 64'(r_s[1]) * 64'(r_c[0]) + (64'sd1 <<< 29);
    t_cval r_a_sysx, r_a_sycx, r_a_sx, r_a_cx, r_a_sy, r_a_cy, r_a_sz, r_a_cz;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_sysx <= 34'(sysx_w >>> 30);
            r_a_sycx <= 34'(sycx_w >>> 30);
            r_a_sx <= r_s[0]; r_a_cx <= r_c[0];
            r_a_sy <= r_s[1]; r_a_cy <= r_c[1];
            r_a_sz <= r_s[2]; r_a_cz <= r_c[2];
        end
    end

    // Stage B: the two-factor products at Q60.
    logic signed [63:0] r_b [0:13];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b[0] <= 64'(r_a_cz) * 64'(r_a_cy);
            r_b[1] <= 64'(r_a_cz) * 64'(r_a_sysx);
            r_b[2] <= 64'(r_a_sz) * 64'(r_a_cx);
            r_b[3] <= 64'(r_a_cz) * 64'(r_a_sycx);
            r_b[4] <= 64'(r_a_sz) * 64'(r_a_sx);
            r_b[5] <= 64'(r_a_sz) * 64'(r_a_cy);
            r_b[6] <= 64'(r_a_sz) * 64'(r_a_sysx);
            r_b[7] <= 64'(r_a_cz) * 64'(r_a_cx);
            r_b[8] <= 64'(r_a_sz) * 64'(r_a_sycx);
            r_b[9] <= 64'(r_a_cz) * 64'(r_a_sx);
            r_b[10] <= -(64'(r_a_sy) <<< 30);
            r_b[11] <= 64'(r_a_cy) * 64'(r_a_sx);
            r_b[12] <= 64'(r_a_cy) * 64'(r_a_cx);
            r_b[13] <= '0;
        end
    end

    // Stage C: sums, rounding and saturation into the output register.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_mat.m00 <= to_q14(r_b[0]);
            o_mat.m01 <= to_q14(r_b[1] - r_b[2]);
            o_mat.m02 <= to_q14(r_b[3] + r_b[4]);
            o_mat.m10 <= to_q14(r_b[5]);
            o_mat.m11 <= to_q14(r_b[6] + r_b[7]);
            o_mat.m12 <= to_q14(r_b[8] - r_b[9]);
            o_mat.m20 <= to_q14(r_b[10] + r_b[13]);
            o_mat.m21 <= to_q14(r_b[11]);
            o_mat.m22 <= to_q14(r_b[12]);
            o_mat.tx <= r_p[0][Depth-2];
            o_mat.ty <= r_p[1][Depth-2];
            o_mat.tz <= r_p[2][Depth-2];
        end
    end
endmodule

/* bench/tb_euler_pose_to_model_matrix_unit.sv */
module tb_euler_pose_to_model_matrix_unit;
    import epm_pkg::*;

    // Stall stretch is long enough to fill every pipeline stage and the front queue.
    localparam int Latency = NSteps + 5;
    localparam int IdleLimit = 2000;
    localparam int LongHold = 3 * Latency + 20;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    epm_stream_if #(.T(t_pose)) pose_if ();
    epm_stream_if #(.T(t_matrix)) mat_if ();

    euler_pose_to_model_matrix_unit uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_pose(pose_if.sink),
        .o_mat(mat_if.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Items waiting to be offered, and matrices waiting to come out.
    t_pose pending_poses[$];
    t_matrix awaited_matrices[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_output = 1'b0;
    int hold_cycles = 0;
    bit drain_pause = 1'b0;
    int mismatches = 0;
    int poses_sent = 0;
    int matrices_seen = 0;
    int idle_count = 0;

    // Floor shift on a signed 64-bit value; >>> on a signed operand floors already.
    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Sine and cosine of a binary angle in Q1.30 by rotation-mode CORDIC.
    function automatic void angle_sin_cos(input logic [15:0] ang, output longint s_q30,
                                          output longint c_q30);
        longint atan_tab[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
        logic [1:0] quad;
        logic [15:0] resid;
        longint x, y, z, nx, ny, c, s;
        quad = 2'((({16'd0, ang} + 32'h2000) >> 14) & 3);
        resid = ang - 16'({quad, 14'd0});
        x = CordicX0;
        y = 0;
        z = longint'($signed(resid)) * 65536;
        for (int i = 0; i < NSteps; i++) begin
            if (z >= 0) begin
                nx = x - fshift(y, i);
                ny = y + fshift(x, i);
                z -= atan_tab[i];
            end else begin
                nx = x + fshift(y, i);
                ny = y - fshift(x, i);
                z += atan_tab[i];
            end
            x = nx;
            y = ny;
        end
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        c_q30 = clamp(c, -OneQ30, OneQ30);
        s_q30 = clamp(s, -OneQ30, OneQ30);
    endfunction

    function automatic logic signed [15:0] q60_to_q14(longint v60);
        return 16'(clamp(fshift(v60 + (64'sd1 <<< 45), 46), -16384, 16384));
    endfunction

    function automatic longint round_to_q30(longint v60);
        return fshift(v60 + (64'sd1 <<< 29), 30);
    endfunction

    // Model matrix R = Rz*Ry*Rx with the position in the fourth column.
    function automatic t_matrix pose_to_matrix(t_pose p);
        t_matrix m;
        longint sx, cx, sy, cy, sz, cz, sysx, sycx;
        angle_sin_cos(p.angle_x, sx, cx);
        angle_sin_cos(p.angle_y, sy, cy);
        angle_sin_cos(p.angle_z, sz, cz);
        sysx = round_to_q30(sy * sx);
        sycx = round_to_q30(sy * cx);
        m.m00 = q60_to_q14(cz * cy);
        m.m01 = q60_to_q14(cz * sysx - sz * cx);
        m.m02 = q60_to_q14(cz * sycx + sz * sx);
        m.tx = p.pos_x;
        m.m10 = q60_to_q14(sz * cy);
        m.m11 = q60_to_q14(sz * sysx + cz * cx);
        m.m12 = q60_to_q14(sz * sycx - cz * sx);
        m.ty = p.pos_y;
        m.m20 = q60_to_q14(-sy * OneQ30);
        m.m21 = q60_to_q14(cy * sx);
        m.m22 = q60_to_q14(cy * cx);
        m.tz = p.pos_z;
        return m;
    endfunction

    function automatic t_pose make_pose(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                                        logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        t_pose p;
        p.angle_x = ax;
        p.angle_y = ay;
        p.angle_z = az;
        p.pos_x = px;
        p.pos_y = py;
        p.pos_z = pz;
        return p;
    endfunction

    // Angles are mostly random, with a share near the quadrant boundaries where
    // the nearest-quadrant split and the residual sign change.
    function automatic logic [15:0] pick_angle();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
            return 16'($urandom_range(0, 3) * 16'h4000 + 16'h2000
                       + $signed($urandom_range(0, 6)) - 3);
        end
        if (sel == 3) begin
            return 16'($urandom_range(0, 3) * 16'h4000 + $signed($urandom_range(0, 4)) - 2);
        end
        return 16'($urandom);
    endfunction

    // The driver offers the head of the queue; valid stays high across items
    // when the next one is already waiting and neither a random idle nor a drain pause intervenes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pose_if.valid <= 1'b0;
            pose_if.data <= '0;
        end else begin
            if (pose_if.valid && pose_if.ready) begin
                void'(pending_poses.pop_front());
                poses_sent++;
            end
            if (pose_if.valid && !pose_if.ready) begin
                // An offered item is held until it is taken.
            end else if (pending_poses.size() > 0 && !drain_pause
                         && ($urandom_range(0, 99) >= send_idle_pct)) begin
                pose_if.valid <= 1'b1;
                pose_if.data <= pending_poses[0];
            end else begin
                pose_if.valid <= 1'b0;
            end
        end
    end

    // Prediction is made at acceptance, so it is ordered exactly as the items.
    always @(posedge i_clk) begin
        if (i_rst_n && pose_if.valid && pose_if.ready) begin
            awaited_matrices.push_back(pose_to_matrix(pose_if.data));
        end
    end

    // Receiver ready, with random stalls and a counted long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mat_if.ready <= 1'b0;
        end else if (hold_output) begin
            mat_if.ready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end else begin
            mat_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor: compares each accepted matrix with the oldest prediction.
    always @(posedge i_clk) begin
        t_matrix want;
        t_matrix got;
        if (i_rst_n && mat_if.valid && mat_if.ready) begin
            got = mat_if.data;
            matrices_seen++;
            if (awaited_matrices.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected matrix %h with none awaited", got);
                end
            end else begin
                want = awaited_matrices.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("matrix mismatch: m00 %0d/%0d m01 %0d/%0d m02 %0d/%0d",
                                 want.m00, got.m00, want.m01, got.m01, want.m02, got.m02);
                        $display("  m10 %0d/%0d m11 %0d/%0d m12 %0d/%0d",
                                 want.m10, got.m10, want.m11, got.m11, want.m12, got.m12);
                        $display("  m20 %0d/%0d m21 %0d/%0d m22 %0d/%0d",
                                 want.m20, got.m20, want.m21, got.m21, want.m22, got.m22);
                        $display("  t %h %h %h / %h %h %h",
                                 want.tx, want.ty, want.tz, got.tx, got.ty, got.tz);
                    end
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither side moves an item while work is outstanding and no hold-off is on.
    always @(posedge i_clk) begin
        if ((pose_if.valid && pose_if.ready) || (mat_if.valid && mat_if.ready)
            || !i_rst_n || hold_output || (pending_poses.size() == 0
            && awaited_matrices.size() == 0)) begin
            idle_count <= 0;
        end else if (idle_count >= IdleLimit) begin
            $display("euler_pose_to_model_matrix_unit verification failed");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    task automatic wait_queue_empty();
        while (pending_poses.size() > 0) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        wait_queue_empty();
        while (awaited_matrices.size() > 0 || pose_if.valid) @(posedge i_clk);
    endtask

    task automatic add_random(int count);
        for (int i = 0; i < count; i++) begin
            pending_poses.push_back(make_pose(pick_angle(), pick_angle(), pick_angle(),
                                              $urandom, $urandom, $urandom));
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero pose, every quadrant, the half-way boundary, the
        // extremes of the angles and positions.
        pending_poses.push_back(make_pose(16'h0000, 16'h0000, 16'h0000, '0, '0, '0));
        for (int q = 0; q < 4; q++) begin
            pending_poses.push_back(make_pose(16'(q * 16'h4000), 16'(q * 16'h4000 + 16'h1000),
                                              16'(q * 16'h4000 - 16'h1000),
                                              32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff));
        end
        pending_poses.push_back(make_pose(16'h1fff, 16'h2000, 16'h2001, 32'h0001_0000,
                                          32'hffff_0000, '0));
        pending_poses.push_back(make_pose(16'h5fff, 16'h6000, 16'ha000, '0, '0, 32'h1));
        pending_poses.push_back(make_pose(16'h8000, 16'h7fff, 16'hffff, 32'h8000_0000,
                                          32'h7fff_ffff, 32'h5555_5555));
        pending_poses.push_back(make_pose(16'hffff, 16'h8000, 16'h7fff, 32'haaaa_aaaa,
                                          32'h5555_5555, 32'h8000_0000));
        pending_poses.push_back(make_pose(16'h4000, 16'hc000, 16'h4000, '1, '1, '1));
        pending_poses.push_back(make_pose(16'hc000, 16'h4000, 16'h8000, '0, '1, '0));
        pending_poses.push_back(make_pose(16'he001, 16'hdfff, 16'h5555, 32'h1234_5678,
                                          32'h9abc_def0, 32'h0f0f_0f0f));
        wait_drained();

        // No idling on either side.
        add_random(150);
        wait_queue_empty();

        // Long receiver hold-off while the sender keeps offering, to fill the pipe.
        hold_output = 1'b1;
        add_random(60);
        while (hold_cycles < LongHold) @(posedge i_clk);
        hold_output = 1'b0;
        wait_drained();

        send_idle_pct = 71;
        add_random(150);
        wait_queue_empty();

        // Sender stops until every result has come out.
        drain_pause = 1'b1;
        add_random(20);
        while (awaited_matrices.size() > 0) @(posedge i_clk);
        drain_pause = 1'b0;

        send_idle_pct = 0;
        recv_stall_pct = 71;
        add_random(150);
        wait_queue_empty();

        send_idle_pct = 30;
        recv_stall_pct = 30;
        add_random(150);
        wait_queue_empty();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        add_random(60);
        wait_drained();
        repeat (2 * Latency) @(posedge i_clk);

        $display("Run covered %0d poses in and %0d matrices out over no-idle, sender-idle,",
                 poses_sent, matrices_seen);
        $display("receiver-stall, mixed and long hold-off phases; %0d mismatches.", mismatches);
        if (mismatches == 0 && awaited_matrices.size() == 0) begin
            $display("euler_pose_to_model_matrix_unit verification clean");
        end else begin
            $display("euler_pose_to_model_matrix_unit verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/epm_pkg.sv
rtl/epm_stream_if.sv
rtl/epm_front.sv
rtl/epm_back.sv
rtl/euler_pose_to_model_matrix_unit.sv
bench/tb_euler_pose_to_model_matrix_unit.sv
